@@ hdl/sign_mask_tangent_propagator_top_macros.svh @@
// assertion macros for the sign mask tangent propagator
`ifndef SIGN_MASK_TANGENT_PROPAGATOR_TOP_MACROS_SVH
`define SIGN_MASK_TANGENT_PROPAGATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define SMTP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SMTP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SMTP_ASSERT_IMPL(label, clk, rstn, ante, cons)

`define SMTP_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/smtp_pkg.sv @@
// package with types, constants and rule functions of the sign mask tangent propagator
`default_nettype none

package smtp_pkg;

  typedef enum logic [1:0] {
    OP_AND = 2'd0,
    OP_OR  = 2'd1,
    OP_XOR = 2'd2
  } op_e;

  localparam int unsigned DataWidth = 64;
  localparam int unsigned HalfWidth = 32;
  localparam logic PassModeReset = 1'b0;

  localparam logic [DataWidth-1:0] Sign64 = 64'h8000_0000_0000_0000;
  localparam logic [DataWidth-1:0] Abs64  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DataWidth-1:0] All64  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [DataWidth-1:0] Inf64  = 64'h7FF0_0000_0000_0000;
  localparam logic [DataWidth-1:0] Sign32 = 64'h0000_0000_8000_0000;
  localparam logic [DataWidth-1:0] Abs32  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [DataWidth-1:0] All32  = 64'h0000_0000_FFFF_FFFF;
  localparam logic [DataWidth-1:0] Inf32  = 64'h0000_0000_7F80_0000;

  localparam int unsigned CtxWide = 0;
  localparam int unsigned CtxLo   = 1;
  localparam int unsigned CtxHi   = 2;
  localparam int unsigned NumCtx  = 3;

  typedef struct packed {
    logic abs_mask;
    logic ones;
    logic sign;
    logic zero;
    logic ad_zero;
    logic b_neg;
    logic b_pos;
  } side_flags_t;

  typedef struct packed {
    side_flags_t x_side;
    side_flags_t y_side;
  } ctx_flags_t;

  typedef struct packed {
    logic [1:0]           op;
    logic                 wide;
    logic [DataWidth-1:0] x_bits;
    logic [DataWidth-1:0] x_tangent;
    logic [DataWidth-1:0] y_bits;
    logic [DataWidth-1:0] y_tangent;
    ctx_flags_t [NumCtx-1:0] flags;
  } s1_t;

  typedef struct packed {
    logic                 hit;
    logic [DataWidth-1:0] value;
  } ctx_res_t;

  typedef struct packed {
    logic                 hit;
    logic [HalfWidth-1:0] value;
  } half_res_t;

  typedef struct packed {
    logic      wide;
    ctx_res_t  wide_res;
    half_res_t lo_res;
    half_res_t hi_res;
  } s2_t;

  function automatic logic [DataWidth-1:0] lo_ext(logic [DataWidth-1:0] v);
    return {{(DataWidth-HalfWidth){1'b0}}, v[HalfWidth-1:0]};
  endfunction

  function automatic logic [DataWidth-1:0] hi_ext(logic [DataWidth-1:0] v);
    return {{(DataWidth-HalfWidth){1'b0}}, v[DataWidth-1:HalfWidth]};
  endfunction

  function automatic side_flags_t classify(logic [DataWidth-1:0] a, logic [DataWidth-1:0] ad,
                                           logic [DataWidth-1:0] b, logic w64);
    side_flags_t          f;
    logic [DataWidth-1:0] sign;
    logic [DataWidth-1:0] absm;
    logic [DataWidth-1:0] all;
    logic [DataWidth-1:0] inf;
    logic [DataWidth-1:0] mag;
    logic                 b_sign;
    logic                 finite_nz;
    sign      = w64 ? Sign64 : Sign32;
    absm      = w64 ? Abs64 : Abs32;
    all       = w64 ? All64 : All32;
    inf       = w64 ? Inf64 : Inf32;
    mag       = b & absm;
    b_sign    = |(b & sign);
    finite_nz = (mag != '0) && (mag <= inf);
    f.abs_mask = (a == absm);
    f.ones     = (a == all);
    f.sign     = (a == sign);
    f.zero     = (a == '0);
    f.ad_zero  = (ad == '0);
    f.b_neg    = b_sign && finite_nz;
    f.b_pos    = !b_sign && finite_nz;
    return f;
  endfunction

  function automatic ctx_res_t resolve_side(logic [1:0] op, side_flags_t f,
                                            logic [DataWidth-1:0] a, logic [DataWidth-1:0] b,
                                            logic [DataWidth-1:0] bd, logic w64, logic pass);
    ctx_res_t             r;
    logic [DataWidth-1:0] sign;
    sign    = w64 ? Sign64 : Sign32;
    r.hit   = 1'b0;
    r.value = '0;
    case (op_e'(op))
      OP_AND: begin
        if (f.abs_mask) begin
          r.hit   = 1'b1;
          r.value = pass ? (a & b) : (f.b_neg ? (bd ^ sign) : bd);
        end else if (f.ones) begin
          r.hit   = 1'b1;
          r.value = bd;
        end
      end
      OP_OR: begin
        if (f.sign && f.ad_zero) begin
          r.hit   = 1'b1;
          r.value = pass ? (a | b) : (f.b_pos ? (bd ^ sign) : bd);
        end else if (f.zero && f.ad_zero) begin
          r.hit   = 1'b1;
          r.value = bd;
        end
      end
      OP_XOR: begin
        if (f.sign && f.ad_zero) begin
          r.hit   = 1'b1;
          r.value = pass ? (a ^ b) : (bd ^ sign);
        end
      end
      default: begin
        r.hit   = 1'b0;
        r.value = '0;
      end
    endcase
    return r;
  endfunction

  function automatic ctx_res_t resolve_ctx(logic [1:0] op, ctx_flags_t f,
                                           logic [DataWidth-1:0] x, logic [DataWidth-1:0] xd,
                                           logic [DataWidth-1:0] y, logic [DataWidth-1:0] yd,
                                           logic w64, logic pass);
    ctx_res_t rx;
    ctx_res_t ry;
    ctx_res_t r;
    rx      = resolve_side(op, f.x_side, x, y, yd, w64, pass);
    ry      = resolve_side(op, f.y_side, y, x, xd, w64, pass);
    r.hit   = rx.hit || ry.hit;
    r.value = rx.hit ? rx.value : ry.value;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/smtp_if.sv @@
// input and output channel interfaces of the sign mask tangent propagator
`default_nettype none

interface smtp_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     op;
  logic                           wide;
  logic [smtp_pkg::DataWidth-1:0] x_bits;
  logic [smtp_pkg::DataWidth-1:0] x_tangent;
  logic [smtp_pkg::DataWidth-1:0] y_bits;
  logic [smtp_pkg::DataWidth-1:0] y_tangent;

  modport source (
    output valid, op, wide, x_bits, x_tangent, y_bits, y_tangent,
    input  ready
  );

  modport sink (
    input  valid, op, wide, x_bits, x_tangent, y_bits, y_tangent,
    output ready
  );
endinterface

interface smtp_out_if;
  logic                           valid;
  logic                           ready;
  logic [smtp_pkg::DataWidth-1:0] result_tangent;

  modport source (
    output valid, result_tangent,
    input  ready
  );

  modport sink (
    input  valid, result_tangent,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/sign_mask_tangent_propagator_top.sv @@
// top level of the sign mask tangent propagator
//
//   channel   direction  fields
//   in_i      sink       op, wide, x_bits, x_tangent, y_bits, y_tangent
//   out_o     source     result_tangent
//   cfg       write      cfg_we_i, cfg_wdata_i (pass_bits_mode)
//
// three register stages: compare, rule select, merge into the output register
// one transaction per cycle sustained while out_o.ready stays high
// each stage takes a new transaction when empty or when its successor takes its own
// reset clears all stage valids and pass_bits_mode, payload registers are not reset
`default_nettype none

`include "sign_mask_tangent_propagator_top_macros.svh"

module sign_mask_tangent_propagator_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i,
  smtp_in_if.sink   in_i,
  smtp_out_if.source out_o
);

  logic          pass_q;
  logic          pass_d;
  logic          s1_valid;
  logic          s1_ready;
  smtp_pkg::s1_t s1_data;
  logic          s2_valid;
  logic          s2_ready;
  smtp_pkg::s2_t s2_data;
  logic          pipe_stalled;

  assign pass_d = cfg_we_i ? cfg_wdata_i : pass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= smtp_pkg::PassModeReset;
    end else begin
      pass_q <= pass_d;
    end
  end

  smtp_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .op_i        (in_i.op),
    .wide_i      (in_i.wide),
    .x_bits_i    (in_i.x_bits),
    .x_tangent_i (in_i.x_tangent),
    .y_bits_i    (in_i.y_bits),
    .y_tangent_i (in_i.y_tangent),
    .out_valid_o (s1_valid),
    .out_ready_i (s1_ready),
    .out_o       (s1_data)
  );

  smtp_resolve u_resolve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pass_i      (pass_q),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .in_i        (s1_data),
    .out_valid_o (s2_valid),
    .out_ready_i (s2_ready),
    .out_o       (s2_data)
  );

  smtp_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid),
    .in_ready_o  (s2_ready),
    .in_i        (s2_data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (out_o.result_tangent)
  );

  assign pipe_stalled = out_o.valid && !out_o.ready && s1_valid && s2_valid;

  `SMTP_ASSERT_IMPL(a_stall_needs_full_pipe, clk_i, rst_ni, !in_i.ready, pipe_stalled)
  `SMTP_ASSERT_NEXT(a_accept_fills_stage1, clk_i, rst_ni, in_i.valid && in_i.ready, s1_valid)
  `SMTP_ASSERT_NEXT(a_stage2_moves_on, clk_i, rst_ni, s2_valid && s2_ready, out_o.valid)

endmodule

`default_nettype wire

@@ hdl/smtp_classify.sv @@
// first stage: mask compares and float sign tests for the wide and both half contexts
`default_nettype none

module smtp_classify (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     op_i,
  input  wire logic                           wide_i,
  input  wire logic [smtp_pkg::DataWidth-1:0] x_bits_i,
  input  wire logic [smtp_pkg::DataWidth-1:0] x_tangent_i,
  input  wire logic [smtp_pkg::DataWidth-1:0] y_bits_i,
  input  wire logic [smtp_pkg::DataWidth-1:0] y_tangent_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output smtp_pkg::s1_t                       out_o
);

  logic          valid_q;
  logic          valid_d;
  smtp_pkg::s1_t data_q;
  smtp_pkg::s1_t data_d;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign valid_d     = in_ready_o ? in_valid_i : valid_q;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_comb begin
    data_d.op        = op_i;
    data_d.wide      = wide_i;
    data_d.x_bits    = x_bits_i;
    data_d.x_tangent = x_tangent_i;
    data_d.y_bits    = y_bits_i;
    data_d.y_tangent = y_tangent_i;
    data_d.flags[smtp_pkg::CtxWide].x_side =
      smtp_pkg::classify(x_bits_i, x_tangent_i, y_bits_i, 1'b1);
    data_d.flags[smtp_pkg::CtxWide].y_side =
      smtp_pkg::classify(y_bits_i, y_tangent_i, x_bits_i, 1'b1);
    data_d.flags[smtp_pkg::CtxLo].x_side =
      smtp_pkg::classify(smtp_pkg::lo_ext(x_bits_i), smtp_pkg::lo_ext(x_tangent_i),
                         smtp_pkg::lo_ext(y_bits_i), 1'b0);
    data_d.flags[smtp_pkg::CtxLo].y_side =
      smtp_pkg::classify(smtp_pkg::lo_ext(y_bits_i), smtp_pkg::lo_ext(y_tangent_i),
                         smtp_pkg::lo_ext(x_bits_i), 1'b0);
    data_d.flags[smtp_pkg::CtxHi].x_side =
      smtp_pkg::classify(smtp_pkg::hi_ext(x_bits_i), smtp_pkg::hi_ext(x_tangent_i),
                         smtp_pkg::hi_ext(y_bits_i), 1'b0);
    data_d.flags[smtp_pkg::CtxHi].y_side =
      smtp_pkg::classify(smtp_pkg::hi_ext(y_bits_i), smtp_pkg::hi_ext(y_tangent_i),
                         smtp_pkg::hi_ext(x_bits_i), 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/smtp_resolve.sv @@
// second stage: rule selection per context, x side before y side
`default_nettype none

module smtp_resolve (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          pass_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire smtp_pkg::s1_t in_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output smtp_pkg::s2_t      out_o
);

  logic               valid_q;
  logic               valid_d;
  smtp_pkg::s2_t      data_q;
  smtp_pkg::s2_t      data_d;
  smtp_pkg::ctx_res_t lo_full;
  smtp_pkg::ctx_res_t hi_full;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign valid_d     = in_ready_o ? in_valid_i : valid_q;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_comb begin
    lo_full = smtp_pkg::resolve_ctx(in_i.op, in_i.flags[smtp_pkg::CtxLo],
                                    smtp_pkg::lo_ext(in_i.x_bits),
                                    smtp_pkg::lo_ext(in_i.x_tangent),
                                    smtp_pkg::lo_ext(in_i.y_bits),
                                    smtp_pkg::lo_ext(in_i.y_tangent), 1'b0, pass_i);
    hi_full = smtp_pkg::resolve_ctx(in_i.op, in_i.flags[smtp_pkg::CtxHi],
                                    smtp_pkg::hi_ext(in_i.x_bits),
                                    smtp_pkg::hi_ext(in_i.x_tangent),
                                    smtp_pkg::hi_ext(in_i.y_bits),
                                    smtp_pkg::hi_ext(in_i.y_tangent), 1'b0, pass_i);
    data_d.wide     = in_i.wide;
    data_d.wide_res = smtp_pkg::resolve_ctx(in_i.op, in_i.flags[smtp_pkg::CtxWide],
                                            in_i.x_bits, in_i.x_tangent,
                                            in_i.y_bits, in_i.y_tangent, 1'b1, pass_i);
    data_d.lo_res.hit   = lo_full.hit;
    data_d.lo_res.value = lo_full.value[smtp_pkg::HalfWidth-1:0];
    data_d.hi_res.hit   = hi_full.hit;
    data_d.hi_res.value = hi_full.value[smtp_pkg::HalfWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/smtp_merge.sv @@
// third stage: wide hit, else joined halves; narrow: low half only; output register
`default_nettype none

module smtp_merge (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire smtp_pkg::s2_t           in_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [smtp_pkg::DataWidth-1:0] out_o
);

  logic                           valid_q;
  logic                           valid_d;
  logic [smtp_pkg::DataWidth-1:0] result_q;
  logic [smtp_pkg::DataWidth-1:0] result_d;
  logic [smtp_pkg::HalfWidth-1:0] lo_val;
  logic [smtp_pkg::HalfWidth-1:0] hi_val;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign valid_d     = in_ready_o ? in_valid_i : valid_q;
  assign out_valid_o = valid_q;
  assign out_o       = result_q;

  always_comb begin
    lo_val = in_i.lo_res.hit ? in_i.lo_res.value : '0;
    hi_val = in_i.hi_res.hit ? in_i.hi_res.value : '0;
    if (!in_i.wide) begin
      result_d = {{(smtp_pkg::DataWidth-smtp_pkg::HalfWidth){1'b0}}, lo_val};
    end else if (in_i.wide_res.hit) begin
      result_d = in_i.wide_res.value;
    end else begin
      result_d = {hi_val, lo_val};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      result_q <= result_d;
    end
  end

endmodule

`default_nettype wire
